@@ src/elpm_pkg.sv @@
// Shared widths, codes and types for the edit-list position mapper.
package elpm_pkg;

    localparam int CLIP_SLOTS_DEF = 32;
    localparam int POS_BITS_DEF   = 32;

    localparam int DATA_W  = 31;   // data positions and lengths
    localparam int LAST_W  = 32;   // signed last-sample position
    localparam int OFF_W   = 32;   // signed seek offset
    localparam int SLOT_FW = 5;    // slot field on the channels
    localparam int MODE_W  = 2;
    localparam int ACC_MIN_W = 35; // one clip length plus sign and carry

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SEEK = 1'b1;

    localparam logic [MODE_W-1:0] MODE_BEGIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CURRENT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END     = 2'd2;

    localparam logic REG_DATA_LENGTH   = 1'b0;
    localparam logic REG_EDITED_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        OUT_INSIDE   = 3'd0,
        OUT_EOF      = 3'd1,
        OUT_OVERFLOW = 3'd2,
        OUT_NEW_CLIP = 3'd3,
        OUT_NO_MOVE  = 3'd4,
        OUT_LOADED   = 3'd5
    } outcome_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_length;
        logic [DATA_W-1:0] edited_length;
    } cfg_t;

endpackage

@@ src/elpm_in_if.sv @@
// Request channel carrying load and seek items.
interface elpm_in_if;
    import elpm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [SLOT_FW-1:0]       entry_slot;
    logic [DATA_W-1:0]        entry_first;
    logic signed [LAST_W-1:0] entry_last;
    logic signed [OFF_W-1:0]  seek_offset;
    logic [MODE_W-1:0]        seek_mode;

    modport source (
        output valid, action, entry_slot, entry_first, entry_last, seek_offset, seek_mode,
        input  ready
    );
    modport sink (
        input  valid, action, entry_slot, entry_first, entry_last, seek_offset, seek_mode,
        output ready
    );
endinterface

@@ src/elpm_out_if.sv @@
// Result channel carrying one position report per request.
interface elpm_out_if;
    import elpm_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  prior_edited_pos;
    logic [DATA_W-1:0]  new_data_pos;
    logic [SLOT_FW-1:0] new_clip;
    logic [2:0]         outcome;

    modport source (
        output valid, prior_edited_pos, new_data_pos, new_clip, outcome,
        input  ready
    );
    modport sink (
        input  valid, prior_edited_pos, new_data_pos, new_clip, outcome,
        output ready
    );
endinterface

@@ src/elpm_cfg.sv @@
// APB register block holding data_length and edited_length.
module elpm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [elpm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [elpm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [elpm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output elpm_pkg::cfg_t                  cfg
);
    import elpm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_DATA_LENGTH:   cfg_next.data_length   = pwdata[DATA_W-1:0];
                REG_EDITED_LENGTH: cfg_next.edited_length = pwdata[DATA_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DATA_LENGTH:   prdata = CFG_DATA_W'(cfg_reg.data_length);
            REG_EDITED_LENGTH: prdata = CFG_DATA_W'(cfg_reg.edited_length);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ src/elpm_mem.sv @@
// Clip table memory: first/last sample per slot, one read and one write port.
module elpm_mem #(
    parameter int  CLIP_SLOTS = elpm_pkg::CLIP_SLOTS_DEF,
    localparam int SLOT_W     = $clog2(CLIP_SLOTS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [SLOT_W-1:0]                   rd_addr,
    output logic [elpm_pkg::DATA_W-1:0]         rd_first,
    output logic signed [elpm_pkg::LAST_W-1:0]  rd_last,
    input  logic                                wr_en,
    input  logic [SLOT_W-1:0]                   wr_addr,
    input  logic [elpm_pkg::DATA_W-1:0]         wr_first,
    input  logic signed [elpm_pkg::LAST_W-1:0]  wr_last
);
    import elpm_pkg::*;

    localparam int ENTRY_W = DATA_W + LAST_W;

    logic [ENTRY_W-1:0]    mem [CLIP_SLOTS];
    logic [CLIP_SLOTS-1:0] valid_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_first, wr_last};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // never-written slots read as zero, matching the cleared table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_first = rd_valid_reg ? rd_data_reg[ENTRY_W-1:LAST_W] : '0;
    assign rd_last  = rd_valid_reg ? $signed(rd_data_reg[LAST_W-1:0]) : '0;

endmodule

@@ src/elpm_seq.sv @@
// Sequencer: loads clips, sums clip lengths for the current edited position,
// walks the table to map the seek target, and holds the result register.
module elpm_seq #(
    parameter int  CLIP_SLOTS = elpm_pkg::CLIP_SLOTS_DEF,
    parameter int  POS_BITS   = elpm_pkg::POS_BITS_DEF,
    localparam int SLOT_W     = $clog2(CLIP_SLOTS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  elpm_pkg::cfg_t                      cfg,
    elpm_in_if.sink                             item,
    elpm_out_if.source                          result,
    output logic [SLOT_W-1:0]                   rd_addr,
    input  logic [elpm_pkg::DATA_W-1:0]         rd_first,
    input  logic signed [elpm_pkg::LAST_W-1:0]  rd_last,
    output logic                                wr_en,
    output logic [SLOT_W-1:0]                   wr_addr,
    output logic [elpm_pkg::DATA_W-1:0]         wr_first,
    output logic signed [elpm_pkg::LAST_W-1:0]  wr_last
);
    import elpm_pkg::*;

    localparam int CNT_W = $clog2(CLIP_SLOTS + 1);
    localparam int ACC_W = (ACC_MIN_W + CNT_W > POS_BITS + 1) ?
                           (ACC_MIN_W + CNT_W) : (POS_BITS + 1);
    localparam logic signed [ACC_W-1:0] ONE_X = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] POS_MAX_X = (ONE_X <<< (POS_BITS - 1)) - ONE_X;
    localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(CLIP_SLOTS);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CLIP_SLOTS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HERE = 6'b000010,
        S_TGT  = 6'b000100,
        S_WALK = 6'b001000,
        S_END  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          ridx_reg, ridx_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   here_reg, here_next;
    logic signed [ACC_W-1:0]   target_reg, target_next;
    logic [DATA_W-1:0]         cur_pos_reg, cur_pos_next;
    logic [SLOT_W-1:0]         cur_clip_reg, cur_clip_next;
    logic signed [OFF_W-1:0]   offset_reg, offset_next;
    logic [MODE_W-1:0]         mode_reg, mode_next;
    logic [DATA_W-1:0]         prev_first_reg, prev_first_next;
    logic signed [LAST_W-1:0]  prev_last_reg, prev_last_next;
    logic [DATA_W-1:0]         prior_reg, prior_next;
    outcome_t                  outcome_reg, outcome_next;

    logic                      out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]         out_prior_reg, out_prior_next;
    logic [DATA_W-1:0]         out_pos_reg, out_pos_next;
    logic [SLOT_FW-1:0]        out_clip_reg, out_clip_next;
    outcome_t                  out_outcome_reg, out_outcome_next;

    logic                      accept;
    logic                      out_free;
    logic [CNT_W-1:0]          ridx_inc;
    logic [CNT_W-1:0]          ridx_dec;
    logic signed [ACC_W-1:0]   first_x, last_x, len_x, diff_x;
    logic signed [ACC_W-1:0]   cur_pos_x, prev_last_x, dl_x, el_x, off_x;
    logic signed [ACC_W-1:0]   tgt_sum_x, map_pos_x;
    logic                      hit;
    logic [DATA_W-1:0]         cur_pos_sat;
    logic [DATA_W-1:0]         prior_sat;
    logic [DATA_W-1:0]         dl_m1_low;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign ridx_inc = ridx_reg + CNT_W'(1);
    assign ridx_dec = ridx_reg - CNT_W'(1);

    assign first_x     = ACC_W'(rd_first);
    assign last_x      = {{(ACC_W-LAST_W){rd_last[LAST_W-1]}}, rd_last};
    assign len_x       = last_x - first_x + ONE_X;
    assign diff_x      = target_reg - acc_reg;
    assign hit         = !diff_x[ACC_W-1] && (diff_x < len_x);
    assign map_pos_x   = first_x + diff_x;
    assign cur_pos_x   = ACC_W'(cur_pos_reg);
    assign prev_last_x = {{(ACC_W-LAST_W){prev_last_reg[LAST_W-1]}}, prev_last_reg};
    assign dl_x        = ACC_W'(cfg.data_length);
    assign el_x        = ACC_W'(cfg.edited_length);
    assign off_x       = {{(ACC_W-OFF_W){offset_reg[OFF_W-1]}}, offset_reg};
    assign dl_m1_low   = cfg.data_length - DATA_W'(1);

    always_comb
    begin
        case (mode_reg)
            MODE_END:     tgt_sum_x = off_x + el_x;
            MODE_CURRENT: tgt_sum_x = off_x + here_reg;
            default:      tgt_sum_x = off_x;
        endcase
    end

    always_comb
    begin
        if (cur_pos_x > POS_MAX_X)
        begin
            cur_pos_sat = POS_MAX_X[DATA_W-1:0];
        end
        else
        begin
            cur_pos_sat = cur_pos_reg;
        end
        if (here_reg[ACC_W-1])
        begin
            prior_sat = '0;
        end
        else if (here_reg > POS_MAX_X)
        begin
            prior_sat = POS_MAX_X[DATA_W-1:0];
        end
        else
        begin
            prior_sat = here_reg[DATA_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ridx_next       = ridx_reg;
        acc_next        = acc_reg;
        here_next       = here_reg;
        target_next     = target_reg;
        cur_pos_next    = cur_pos_reg;
        cur_clip_next   = cur_clip_reg;
        offset_next     = offset_reg;
        mode_next       = mode_reg;
        prev_first_next = prev_first_reg;
        prev_last_next  = prev_last_reg;
        prior_next      = prior_reg;
        outcome_next    = outcome_reg;

        out_valid_next   = out_valid_reg && !result.ready;
        out_prior_next   = out_prior_reg;
        out_pos_next     = out_pos_reg;
        out_clip_next    = out_clip_reg;
        out_outcome_next = out_outcome_reg;

        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = SLOT_W'(item.entry_slot);
        wr_first = item.entry_first;
        wr_last  = item.entry_last;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ridx_next   = '0;
                    acc_next    = '0;
                    offset_next = item.seek_offset;
                    mode_next   = item.seek_mode;
                    if (item.action == ACT_LOAD)
                    begin
                        wr_en        = (32'(item.entry_slot) < 32'(CLIP_SLOTS));
                        prior_next   = '0;
                        outcome_next = OUT_LOADED;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_HERE;
                    end
                end
            end

            // sum lengths of clips before the current one, then the offset into it
            S_HERE:
            begin
                rd_addr = ridx_inc[SLOT_W-1:0];
                if (ridx_reg == CNT_W'(cur_clip_reg))
                begin
                    here_next  = acc_reg + cur_pos_x - first_x;
                    state_next = S_TGT;
                end
                else
                begin
                    acc_next  = acc_reg + len_x;
                    ridx_next = ridx_inc;
                end
            end

            S_TGT:
            begin
                rd_addr    = '0;
                prior_next = prior_sat;
                if (mode_reg == MODE_CURRENT && offset_reg == '0)
                begin
                    outcome_next = OUT_NO_MOVE;
                    state_next   = S_DONE;
                end
                else
                begin
                    target_next = tgt_sum_x[ACC_W-1] ? '0 : tgt_sum_x;
                    acc_next    = '0;
                    ridx_next   = '0;
                    state_next  = S_WALK;
                end
            end

            S_WALK:
            begin
                rd_addr = ridx_inc[SLOT_W-1:0];
                if (rd_last == '0)
                begin
                    state_next = S_END;
                end
                else if (hit)
                begin
                    cur_pos_next  = map_pos_x[DATA_W-1:0];
                    cur_clip_next = ridx_reg[SLOT_W-1:0];
                    outcome_next  = OUT_INSIDE;
                    state_next    = S_DONE;
                end
                else
                begin
                    acc_next        = acc_reg + len_x;
                    prev_first_next = rd_first;
                    prev_last_next  = rd_last;
                    ridx_next       = ridx_inc;
                    if (ridx_reg == CNT_LAST)
                    begin
                        state_next = S_END;
                    end
                end
            end

            // ran past the table: end of data, overflow, or append an empty clip
            S_END:
            begin
                state_next = S_DONE;
                if (ridx_reg != '0 && prev_last_x == dl_x - ONE_X && target_reg == el_x)
                begin
                    cur_pos_next  = cfg.data_length;
                    cur_clip_next = ridx_dec[SLOT_W-1:0];
                    outcome_next  = OUT_EOF;
                end
                else if (ridx_reg == CNT_SLOTS)
                begin
                    cur_pos_next  = prev_first_reg;
                    cur_clip_next = CNT_LAST[SLOT_W-1:0];
                    outcome_next  = OUT_OVERFLOW;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = ridx_reg[SLOT_W-1:0];
                    wr_first      = cfg.data_length;
                    wr_last       = (cfg.data_length == '0) ? '1 : $signed({1'b0, dl_m1_low});
                    cur_pos_next  = cfg.data_length;
                    cur_clip_next = ridx_reg[SLOT_W-1:0];
                    outcome_next  = OUT_NEW_CLIP;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    cur_pos_next     = cur_pos_sat;
                    out_valid_next   = 1'b1;
                    out_prior_next   = prior_reg;
                    out_pos_next     = cur_pos_sat;
                    out_clip_next    = SLOT_FW'(cur_clip_reg);
                    out_outcome_next = outcome_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_pos_reg   <= '0;
            cur_clip_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_pos_reg   <= cur_pos_next;
            cur_clip_reg  <= cur_clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg        <= ridx_next;
        acc_reg         <= acc_next;
        here_reg        <= here_next;
        target_reg      <= target_next;
        offset_reg      <= offset_next;
        mode_reg        <= mode_next;
        prev_first_reg  <= prev_first_next;
        prev_last_reg   <= prev_last_next;
        prior_reg       <= prior_next;
        outcome_reg     <= outcome_next;
        out_prior_reg   <= out_prior_next;
        out_pos_reg     <= out_pos_next;
        out_clip_reg    <= out_clip_next;
        out_outcome_reg <= out_outcome_next;
    end

    assign item.ready              = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.prior_edited_pos = out_prior_reg;
    assign result.new_data_pos     = out_pos_reg;
    assign result.new_clip         = out_clip_reg;
    assign result.outcome          = out_outcome_reg;

endmodule

@@ src/edit_list_position_mapper_top.sv @@
// Edit-list position mapper: clip table, seek sequencer and APB registers.
//
// item channel (valid/ready): action 0 loads one clip entry into entry_slot,
// action 1 seeks by seek_offset from the start, current position or end
// (seek_mode). Every request yields exactly one result on the result channel:
// the prior edited position, the new data position and clip, and an outcome.
// A load goes from idle to the done state, which registers the result once
// the output register is free. A seek first reads clips 0..current clip to
// rebuild the edited position, then forms the target (a zero-offset seek from
// the current position ends there), walks the table one clip per cycle via the
// single memory read port until it finds the target or hits the table end, and
// takes the end state past the table end; the done state registers the result.
// One request is in flight at a time; item.ready is high while the sequencer
// is idle, so a new request is taken while a result still waits in the
// output register, in the cycle after the previous result was registered.
// A stalled result holds the sequencer in its last step.
// Reset empties the clip table (slots read as zero), zeroes the current
// position, clip and both length registers. The registers are written
// through APB at byte addresses 0 (data_length) and 4 (edited_length).
module edit_list_position_mapper_top #(
    parameter int CLIP_SLOTS = elpm_pkg::CLIP_SLOTS_DEF,
    parameter int POS_BITS   = elpm_pkg::POS_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [elpm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [elpm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [elpm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    elpm_in_if.sink                         item,
    elpm_out_if.source                      result
);
    import elpm_pkg::*;

    localparam int SLOT_W = $clog2(CLIP_SLOTS);

    cfg_t                     cfg;
    logic [SLOT_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_first;
    logic signed [LAST_W-1:0] rd_last;
    logic                     wr_en;
    logic [SLOT_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_first;
    logic signed [LAST_W-1:0] wr_last;

    elpm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    elpm_mem #(
        .CLIP_SLOTS (CLIP_SLOTS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_first (rd_first),
        .rd_last  (rd_last),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_first (wr_first),
        .wr_last  (wr_last)
    );

    elpm_seq #(
        .CLIP_SLOTS (CLIP_SLOTS),
        .POS_BITS   (POS_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .item     (item),
        .result   (result),
        .rd_addr  (rd_addr),
        .rd_first (rd_first),
        .rd_last  (rd_last),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_first (wr_first),
        .wr_last  (wr_last)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the edit-list position mapper: directed table, then random clip tables and seeks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import elpm_pkg::*;

    localparam int     SLOTS       = CLIP_SLOTS_DEF;
    localparam longint POS_TOP     = (longint'(1) << (POS_BITS_DEF - 1)) - 1;
    localparam int     ITEMS       = 1350;
    localparam int     HOLD_CYCLES = 300;
    localparam int     QUIET_LIMIT = 4000;
    localparam int     DRAIN_WAIT  = 80;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]  prior;
        logic [DATA_W-1:0]  data_pos;
        logic [SLOT_FW-1:0] clip;
        outcome_t           outcome;
    } report_t;

    typedef struct packed {
        logic                     action;
        logic [SLOT_FW-1:0]       slot;
        logic [DATA_W-1:0]        first;
        logic signed [LAST_W-1:0] last;
        logic signed [OFF_W-1:0]  offset;
        logic [MODE_W-1:0]        mode;
    } request_t;

    typedef enum logic [1:0] {STEP_LOAD, STEP_SEEK, STEP_DATA_LEN, STEP_EDIT_LEN} step_kind_t;

    // arg is the last sample for a load and the offset for a seek;
    // first doubles as the register value
    typedef struct packed {
        step_kind_t         kind;
        logic [SLOT_FW-1:0] slot;
        logic [DATA_W-1:0]  first;
        logic signed [31:0] arg;
        logic [MODE_W-1:0]  mode;
        logic               typed;
        report_t            want;
    } step_t;

    localparam report_t NO_REPORT   = '0;
    localparam report_t REP_FRESH   = '{31'd0, 31'd0, 5'd0, OUT_NEW_CLIP};
    localparam report_t REP_STILL   = '{31'd0, 31'd0, 5'd0, OUT_NO_MOVE};
    localparam report_t REP_LOADED0 = '{31'd0, 31'd0, 5'd0, OUT_LOADED};

    localparam logic [DATA_W-1:0] FIRST_MAX = 31'h7FFF_FFFF;
    localparam logic signed [31:0] OFF_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] OFF_MAX  = 32'sh7FFF_FFFF;

    localparam int DIR_N = 26;
    step_t dir_steps [DIR_N] = '{
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd0, MODE_BEGIN, 1'b1, REP_FRESH},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd0, MODE_CURRENT, 1'b1, REP_STILL},
        '{STEP_LOAD, 5'd0, 31'd10, 32'sd19, MODE_BEGIN, 1'b1, REP_LOADED0},
        '{STEP_LOAD, 5'd1, 31'd100, 32'sd104, MODE_BEGIN, 1'b1, REP_LOADED0},
        '{STEP_LOAD, 5'd2, FIRST_MAX, OFF_MAX, MODE_BEGIN, 1'b1, REP_LOADED0},
        '{STEP_LOAD, 5'd3, 31'd0, 32'sd0, MODE_BEGIN, 1'b1, REP_LOADED0},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd12, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd10, MODE_CURRENT, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, -32'sd1, MODE_END, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, OFF_MIN, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, OFF_MAX, MODE_CURRENT, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd11, MODE_SPARE, 1'b0, NO_REPORT},
        '{STEP_LOAD, 5'd31, 31'd0, -32'sd1, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_LOAD, 5'd2, 31'd105, 32'sd119, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_LOAD, 5'd3, 31'd0, 32'sd0, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_DATA_LEN, 5'd0, 31'd120, 32'sd0, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_EDIT_LEN, 5'd0, 31'd30, 32'sd0, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd0, MODE_END, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd29, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd0, MODE_CURRENT, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd1, MODE_CURRENT, 1'b0, NO_REPORT},
        '{STEP_DATA_LEN, 5'd0, FIRST_MAX, 32'sd0, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_EDIT_LEN, 5'd0, FIRST_MAX, 32'sd0, MODE_BEGIN, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd0, MODE_END, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, 32'sd1, MODE_END, 1'b0, NO_REPORT},
        '{STEP_SEEK, 5'd0, 31'd0, OFF_MIN, MODE_CURRENT, 1'b0, NO_REPORT}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    elpm_in_if  in_ch ();
    elpm_out_if out_ch ();

    edit_list_position_mapper_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (in_ch),
        .result  (out_ch)
    );

    always #6 clk = ~clk;

    // mirror of the clip table, position and length registers
    longint tbl_first [SLOTS];
    longint tbl_last  [SLOTS];
    longint at_pos;
    int     at_clip;
    longint cfg_data_len;
    longint cfg_edit_len;

    report_t expected_reports [$];
    int      mismatches;
    int      accepted_reqs;
    int      idle_pct;
    int      stall_pct;
    int      hold_reqs;
    int      holds_done;
    int      quiet;

    function automatic longint clamp_pos(longint v);
        if (v < 0)
            return 0;
        if (v > POS_TOP)
            return POS_TOP;
        return v;
    endfunction

    function automatic longint clip_span(int i);
        return tbl_last[i] - tbl_first[i] + 1;
    endfunction

    function automatic longint edited_at();
        longint pos;
        pos = 0;
        for (int i = 0; i < at_clip; i++)
            pos += clip_span(i);
        return pos + at_pos - tbl_first[at_clip];
    endfunction

    function automatic outcome_t walk_to(longint target);
        longint epos;
        longint len;
        int     i;
        epos = 0;
        i = 0;
        while (i < SLOTS && tbl_last[i] != 0) begin
            len = clip_span(i);
            if (target >= epos && target < epos + len) begin
                at_pos  = tbl_first[i] + target - epos;
                at_clip = i;
                return OUT_INSIDE;
            end
            epos += len;
            i++;
        end
        if (i > 0 && tbl_last[i - 1] == cfg_data_len - 1 && target == cfg_edit_len) begin
            at_pos  = cfg_data_len;
            at_clip = i - 1;
            return OUT_EOF;
        end
        if (i >= SLOTS) begin
            at_pos  = tbl_first[SLOTS - 1];
            at_clip = SLOTS - 1;
            return OUT_OVERFLOW;
        end
        // table runs out: open an empty clip at the end of the data
        tbl_first[i] = cfg_data_len;
        tbl_last[i]  = cfg_data_len - 1;
        at_pos  = cfg_data_len;
        at_clip = i;
        return OUT_NEW_CLIP;
    endfunction

    function automatic report_t map_request(request_t r);
        report_t rep;
        longint  here;
        longint  target;
        rep = '0;
        if (r.action == ACT_LOAD) begin
            tbl_first[r.slot] = r.first;
            tbl_last[r.slot]  = $signed(r.last);
            rep.outcome = OUT_LOADED;
        end else begin
            here = edited_at();
            rep.prior = DATA_W'(clamp_pos(here));
            if (r.offset == 0 && r.mode == MODE_CURRENT) begin
                rep.outcome = OUT_NO_MOVE;
            end else begin
                target = $signed(r.offset);
                if (r.mode == MODE_END)
                    target += cfg_edit_len;
                else if (r.mode == MODE_CURRENT)
                    target += here;
                if (target < 0)
                    target = 0;
                rep.outcome = walk_to(target);
                at_pos = clamp_pos(at_pos);
            end
        end
        rep.data_pos = DATA_W'(clamp_pos(at_pos));
        rep.clip     = SLOT_FW'(at_clip);
        return rep;
    endfunction

    // every field random; callers overwrite the ones that matter
    function automatic request_t fresh_request();
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        return noise[$bits(request_t)-1:0];
    endfunction

    task automatic push_req(input request_t r, input logic typed, input report_t want);
        report_t predicted;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= r.action;
        in_ch.entry_slot  <= r.slot;
        in_ch.entry_first <= r.first;
        in_ch.entry_last  <= r.last;
        in_ch.seek_offset <= r.offset;
        in_ch.seek_mode   <= r.mode;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = map_request(r);
        expected_reports.push_back(typed ? want : predicted);
        accepted_reqs++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {1'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == REG_DATA_LENGTH)
            cfg_data_len = val;
        else
            cfg_edit_len = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_segment(input int seg);
        int                n;
        int                pick;
        longint            fst;
        longint            span;
        longint            lst;
        longint            total;
        longint            last_end;
        longint            val;
        logic [DATA_W-1:0] dlen;
        logic [DATA_W-1:0] elen;
        request_t          r;
        case (seg % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; end
            default: begin idle_pct = 20; stall_pct = 20; end
        endcase

        // contiguous-ish clip table, sometimes filling every slot
        n = ($urandom_range(3) == 0) ? SLOTS : $urandom_range(1, SLOTS - 1);
        fst = $urandom_range(2, 500);
        total = 0;
        last_end = 0;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                span = 0;
            else if (pick < 15)
                span = $urandom_range(1, 1 << 24);
            else
                span = $urandom_range(1, 40);
            if (pick >= 95)
                fst = $urandom_range(2, 1 << 30);
            if (fst + span - 1 > POS_TOP)
                fst = 1000;
            lst = fst + span - 1;
            r = fresh_request();
            r.action = ACT_LOAD;
            r.slot   = SLOT_FW'(i);
            r.first  = DATA_W'(fst);
            r.last   = LAST_W'(lst);
            push_req(r, 1'b0, NO_REPORT);
            total += span;
            last_end = lst + 1;
            fst = lst + 1 + $urandom_range(20);
        end
        if (n < SLOTS) begin
            r = fresh_request();
            r.action = ACT_LOAD;
            r.slot   = SLOT_FW'(n);
            r.last   = '0;
            push_req(r, 1'b0, NO_REPORT);
        end
        if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                r = fresh_request();
                r.action = ACT_LOAD;
                case ($urandom_range(2))
                    0: r.last = -1;
                    1: r.last = '0;
                    default: r.last[31] = 1'b0;
                endcase
                push_req(r, 1'b0, NO_REPORT);
            end
        end

        settle();
        pick = $urandom_range(9);
        if (pick < 6) begin
            dlen = DATA_W'(last_end);
            elen = DATA_W'(total);
        end else if (pick == 6) begin
            dlen = '0;
            elen = '0;
        end else if (pick == 7) begin
            dlen = '1;
            elen = '1;
        end else begin
            dlen = DATA_W'($urandom);
            elen = DATA_W'($urandom_range(total + 3));
        end
        write_reg(REG_DATA_LENGTH, dlen);
        write_reg(REG_EDITED_LENGTH, elen);

        if (seg % 7 == 3)
            hold_reqs++;

        repeat ($urandom_range(15, 40)) begin
            r = fresh_request();
            r.action = ACT_SEEK;
            pick = $urandom_range(99);
            r.mode = (pick < 33) ? MODE_BEGIN : (pick < 63) ? MODE_CURRENT :
                     (pick < 96) ? MODE_END : MODE_SPARE;
            pick = $urandom_range(99);
            if (pick < 85) begin
                if (pick < 60) begin
                    if (r.mode == MODE_CURRENT)
                        val = longint'($urandom_range(40)) - 20;
                    else if (r.mode == MODE_END)
                        val = -longint'($urandom_range(total + 2));
                    else
                        val = $urandom_range(total + 2);
                end else if (pick < 75) begin
                    if (r.mode == MODE_END)
                        val = longint'($urandom_range(2)) - 1;
                    else if (r.mode == MODE_CURRENT)
                        val = 0;
                    else
                        val = $urandom_range(1) ? total : longint'(elen);
                end else begin
                    val = $urandom_range(1) ? -(longint'(1) << 31) : POS_TOP;
                end
                r.offset = OFF_W'(val);
            end
            push_req(r, 1'b0, NO_REPORT);
        end
    endtask

    task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        report_t want;
        if (out_ch.valid && out_ch.ready) begin
            if (expected_reports.size() == 0) begin
                $error("result with no request pending");
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                note_field("prior_edited_pos", want.prior, out_ch.prior_edited_pos);
                note_field("new_data_pos", want.data_pos, out_ch.new_data_pos);
                note_field("new_clip", want.clip, out_ch.new_clip);
                note_field("outcome", want.outcome, out_ch.outcome);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_done != hold_reqs) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        request_t r;
        int       seg;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_LOAD;
        in_ch.entry_slot  = '0;
        in_ch.entry_first = '0;
        in_ch.entry_last  = '0;
        in_ch.seek_offset = '0;
        in_ch.seek_mode   = MODE_BEGIN;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_steps[k]) begin
            case (dir_steps[k].kind)
                STEP_DATA_LEN: begin
                    settle();
                    write_reg(REG_DATA_LENGTH, dir_steps[k].first);
                end
                STEP_EDIT_LEN: begin
                    settle();
                    write_reg(REG_EDITED_LENGTH, dir_steps[k].first);
                end
                default: begin
                    r = fresh_request();
                    r.action = (dir_steps[k].kind == STEP_SEEK) ? ACT_SEEK : ACT_LOAD;
                    r.slot   = dir_steps[k].slot;
                    r.first  = dir_steps[k].first;
                    r.last   = dir_steps[k].arg;
                    r.offset = dir_steps[k].arg;
                    r.mode   = dir_steps[k].mode;
                    push_req(r, dir_steps[k].typed, dir_steps[k].want);
                end
            endcase
        end

        seg = 0;
        while (accepted_reqs < ITEMS) begin
            run_segment(seg);
            seg++;
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
